FILE: design/flow_proportional_dosing_pump_unit_assert.svh
// assertion macros used by the dosing pump controller
`ifndef FLOW_PROPORTIONAL_DOSING_PUMP_UNIT_ASSERT_SVH
`define FLOW_PROPORTIONAL_DOSING_PUMP_UNIT_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define FPDP_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define FPDP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/fpdp_pkg.sv
// shared types and constants of the dosing pump unit
`default_nettype none
package fpdp_pkg;

    localparam int TIMER_WIDTH_DEF = 24;
    localparam int IN_DATA_W       = 8;
    localparam int OUT_DATA_W      = 48;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 12;
    localparam int DIV_DVD_W       = 24;
    localparam int DIV_DVS_W       = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_RATIO1   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RATIO2   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COOLDOWN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BLINK    = 3'd4;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_ON    = 3'd1,
        PH_OFF   = 3'd2,
        PH_COOL  = 3'd3,
        PH_PRIME = 3'd4
    } phase_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PRE,
        ST_DECIDE,
        ST_AVG_GO,
        ST_AVG_WAIT,
        ST_PREP,
        ST_OFF_GO,
        ST_OFF_WAIT,
        ST_MUL1,
        ST_MUL2,
        ST_ON_GO,
        ST_ON_WAIT,
        ST_COMMIT,
        ST_FINISH
    } ctrl_state_t;

    typedef enum logic [1:0] {
        DIV_AVG,
        DIV_OFF,
        DIV_ON
    } div_sel_t;

    typedef struct packed {
        logic     load;
        logic     pre;
        logic     decide;
        logic     div_start;
        div_sel_t div_sel;
        logic     cap_avg;
        logic     lock_prep;
        logic     cap_off;
        logic     mul1;
        logic     mul2;
        logic     cap_on;
        logic     commit;
        logic     finish;
    } dp_cmd_t;

    typedef struct packed {
        logic need_avg;
        logic need_lock;
        logic full;
        logic div_done;
    } dp_status_t;

endpackage
`default_nettype wire

FILE: design/flow_proportional_dosing_pump_unit.sv
// top level of the flow proportional dosing pump unit
// a tick that locks a new pump cycle may run an average divide and two timing divides,
// 24 steps each on the shared restoring divider
// throughput: one tick at a time, the next input transfer is taken once the result is out
// reset: synchronous active low aresetn restores the register defaults and an idle pump
`default_nettype none
module flow_proportional_dosing_pump_unit #(
    parameter int TIMER_WIDTH = fpdp_pkg::TIMER_WIDTH_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // tick_pulses[3:0], flavor_switch[4], prime_button[5]
    input  wire logic [fpdp_pkg::IN_DATA_W-1:0]  s_tdata,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // pump_drive[0], valve_drive[1], selected_flavor[2], led_first[3], led_second[4],
    // phase_code[7:5], locked_on_ms[31:8], locked_off_ms[41:32]
    output logic [fpdp_pkg::OUT_DATA_W-1:0]      m_tdata,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [fpdp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [fpdp_pkg::CFG_DATA_W-1:0] cfg_data
);
    fpdp_pkg::dp_cmd_t    cmd;
    fpdp_pkg::dp_status_t status;

    assign cfg_ready = 1'b1;

    fpdp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    fpdp_dp #(
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .cmd       (cmd),
        .status    (status),
        .m_tdata   (m_tdata)
    );
endmodule
`default_nettype wire

FILE: design/fpdp_div.sv
// restoring divider, one quotient bit per cycle
`default_nettype none
module fpdp_div (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           start,
    input  wire logic [fpdp_pkg::DIV_DVD_W-1:0] dividend,
    input  wire logic [fpdp_pkg::DIV_DVS_W-1:0] divisor,
    output logic                                done,
    output logic [fpdp_pkg::DIV_DVD_W-1:0]      quotient
);
    localparam int DW = fpdp_pkg::DIV_DVD_W;
    localparam int SW = fpdp_pkg::DIV_DVS_W;
    localparam int CW = $clog2(DW + 1);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [DW-1:0] q_reg, q_next;
    logic [SW-1:0] rem_reg, rem_next;
    logic [SW-1:0] dvs_reg, dvs_next;
    logic [SW:0]   rem_sh;
    logic [SW:0]   diff;
    logic          ge;

    assign rem_sh = {rem_reg, q_reg[DW-1]};
    assign ge     = rem_sh >= {1'b0, dvs_reg};
    assign diff   = rem_sh - {1'b0, dvs_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start) begin
            q_next    = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            busy_next = 1'b1;
            cnt_next  = CW'(DW);
        end else if (busy_reg) begin
            q_next   = {q_reg[DW-2:0], ge};
            rem_next = ge ? diff[SW-1:0] : rem_sh[SW-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        q_reg   <= q_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;
endmodule
`default_nettype wire

FILE: design/fpdp_dp.sv
// datapath: flow window, pump sequencer state, cycle timing and led logic
`default_nettype none
module fpdp_dp #(
    parameter int TIMER_WIDTH = fpdp_pkg::TIMER_WIDTH_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_valid,
    input  wire logic                            cfg_ready,
    input  wire logic [fpdp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [fpdp_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic [fpdp_pkg::IN_DATA_W-1:0]  s_tdata,
    input  wire fpdp_pkg::dp_cmd_t               cmd,
    output fpdp_pkg::dp_status_t                 status,
    output logic [fpdp_pkg::OUT_DATA_W-1:0]      m_tdata
);
    localparam int TW = TIMER_WIDTH;
    localparam logic [TW-1:0] TMAX = {TW{1'b1}};

    // configuration
    logic [4:0]  ratio1_reg, ratio2_reg;
    logic [7:0]  window_reg, blink_ms_reg;
    logic [11:0] cool_reg;

    // captured input
    logic [3:0] pulses_reg;
    logic       sw_reg, prime_reg;

    // state
    fpdp_pkg::phase_t phase_reg, phase_next;
    logic [TW-1:0] elapsed_reg, elapsed_next;
    logic [TW-1:0] on_time_reg, on_time_next;
    logic [9:0]    off_time_reg, off_time_next;
    logic [23:0]   sum_reg, sum_next;
    logic [15:0]   cnt_reg, cnt_next;
    logic          saw_reg, saw_next;
    logic [7:0]    wticks_reg, wticks_next;
    logic [11:0]   wpulses_reg, wpulses_next;
    logic [11:0]   latest_reg, latest_next;
    logic          flowing_reg, flowing_next;
    logic          valve_reg, valve_next;
    logic          blvl_reg, blvl_next;
    logic [7:0]    bel_reg, bel_next;
    logic          flavor_reg, flavor_next;

    // cycle timing working registers
    logic [2:0]  lock_c_reg, lock_c_next;
    logic [6:0]  n_reg, n_next;
    logic [7:0]  onb_reg, onb_next;
    logic [15:0] den_reg, den_next;
    logic [14:0] num_off_reg, num_off_next;
    logic        full_reg, full_next;
    logic [10:0] off_raw_reg, off_raw_next;
    logic [23:0] on_raw_reg, on_raw_next;
    logic [16:0] p1_reg, p1_next;
    logic [23:0] p2_reg, p2_next;
    logic [fpdp_pkg::OUT_DATA_W-1:0] out_reg, out_next;

    // divider
    logic                           div_done;
    logic [fpdp_pkg::DIV_DVD_W-1:0] div_q;
    logic [fpdp_pkg::DIV_DVD_W-1:0] div_dvd;
    logic [fpdp_pkg::DIV_DVS_W-1:0] div_dvs;

    function automatic logic [2:0] clamp_c(input logic [23:0] v);
        if (v < 24'd1) begin
            return 3'd1;
        end else if (v > 24'd6) begin
            return 3'd6;
        end
        return v[2:0];
    endfunction

    always_comb begin
        case (cmd.div_sel)
            fpdp_pkg::DIV_AVG: begin
                div_dvd = sum_reg;
                div_dvs = cnt_reg;
            end
            fpdp_pkg::DIV_OFF: begin
                div_dvd = 24'(num_off_reg);
                div_dvs = 16'(n_reg);
            end
            default: begin
                div_dvd = p2_reg;
                div_dvs = den_reg;
            end
        endcase
    end

    fpdp_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .done     (div_done),
        .quotient (div_q)
    );

    // window update
    logic [12:0] wp_sum;
    logic [11:0] wp_new;
    logic [7:0]  wt_new;
    logic        reading;
    logic [24:0] sum_add;

    assign wp_sum  = {1'b0, wpulses_reg} + 13'(pulses_reg);
    assign wp_new  = wp_sum[12] ? 12'hFFF : wp_sum[11:0];
    assign wt_new  = (wticks_reg != 8'hFF) ? wticks_reg + 8'd1 : wticks_reg;
    assign reading = wt_new >= window_reg;
    assign sum_add = {1'b0, sum_reg} + 25'(wp_new);

    // sequencer decisions
    logic el_ge_on, el_ge_off, el_ge_cool;
    assign el_ge_on   = elapsed_reg >= on_time_reg;
    assign el_ge_off  = elapsed_reg >= TW'(off_time_reg);
    assign el_ge_cool = elapsed_reg >= TW'(cool_reg);

    logic off_restart;
    assign off_restart = !prime_reg && phase_reg == fpdp_pkg::PH_OFF && el_ge_off && !saw_reg;

    assign status.need_avg  = off_restart && cnt_reg != 16'd0;
    assign status.need_lock = (!prime_reg && phase_reg == fpdp_pkg::PH_IDLE
                               && latest_reg != 12'd0)
                              || (off_restart && cnt_reg == 16'd0);
    assign status.full      = full_reg;
    assign status.div_done  = div_done;

    // timing preparation
    logic [4:0]  r_sel, r_cl;
    logic [7:0]  n_w;
    logic [7:0]  onb_w;
    logic [9:0]  offb_w, tot_w;
    logic [14:0] n_onb, tot28;

    assign r_sel  = flavor_reg ? ratio2_reg : ratio1_reg;
    assign r_cl   = (r_sel < 5'd6) ? 5'd6 : ((r_sel > 5'd24) ? 5'd24 : r_sel);
    assign n_w    = 8'd88 - 8'(8'd3 * 8'(r_cl));
    assign onb_w  = 8'd20 + 8'(8'd30 * 8'(lock_c_reg));
    assign offb_w = 10'd660 - 10'(10'd60 * 10'(lock_c_reg));
    assign tot_w  = 10'd680 - 10'(10'd30 * 10'(lock_c_reg));
    assign n_onb  = 15'(n_w) * 15'(onb_w);
    assign tot28  = 15'd28 * 15'(tot_w);

    // locking
    logic [TW-1:0] on_sat;
    always_comb begin
        if (32'(on_raw_reg) > 32'(TMAX)) begin
            on_sat = TMAX;
        end else begin
            on_sat = TW'(on_raw_reg);
        end
        if (on_sat < TW'(50)) begin
            on_sat = TW'(50);
        end
    end

    // valve and led
    logic       should, just_opened, fin_valve, fin_lvl, led_lvl;
    logic [7:0] fin_bel;
    logic [31:0] on_ext;
    always_comb begin
        should      = phase_reg != fpdp_pkg::PH_IDLE || flowing_reg || prime_reg;
        just_opened = 1'b0;
        fin_valve   = valve_reg;
        fin_lvl     = blvl_reg;
        fin_bel     = bel_reg;
        if (should && !valve_reg) begin
            fin_valve   = 1'b1;
            fin_lvl     = 1'b1;
            fin_bel     = '0;
            just_opened = 1'b1;
        end else if (!should && valve_reg) begin
            fin_valve = 1'b0;
        end
        if (fin_valve) begin
            if (!just_opened && fin_bel != 8'hFF) begin
                fin_bel = fin_bel + 8'd1;
            end
            if (fin_bel >= blink_ms_reg) begin
                fin_lvl = !fin_lvl;
                fin_bel = '0;
            end
        end
        led_lvl = fin_valve ? fin_lvl : 1'b1;
    end
    assign on_ext = 32'(on_time_reg);

    always_comb begin
        phase_next    = phase_reg;
        elapsed_next  = elapsed_reg;
        on_time_next  = on_time_reg;
        off_time_next = off_time_reg;
        sum_next      = sum_reg;
        cnt_next      = cnt_reg;
        saw_next      = saw_reg;
        wticks_next   = wticks_reg;
        wpulses_next  = wpulses_reg;
        latest_next   = latest_reg;
        flowing_next  = flowing_reg;
        valve_next    = valve_reg;
        blvl_next     = blvl_reg;
        bel_next      = bel_reg;
        flavor_next   = flavor_reg;
        lock_c_next   = lock_c_reg;
        n_next        = n_reg;
        onb_next      = onb_reg;
        den_next      = den_reg;
        num_off_next  = num_off_reg;
        full_next     = full_reg;
        off_raw_next  = off_raw_reg;
        on_raw_next   = on_raw_reg;
        p1_next       = p1_reg;
        p2_next       = p2_reg;
        out_next      = out_reg;

        if (cmd.pre) begin
            if (sw_reg != flavor_reg && !valve_reg) begin
                flavor_next = sw_reg;
            end
            wpulses_next = wp_new;
            wticks_next  = wt_new;
            if (reading) begin
                wticks_next  = '0;
                wpulses_next = '0;
                latest_next  = wp_new;
                flowing_next = wp_new != 12'd0;
                if (phase_reg == fpdp_pkg::PH_ON || phase_reg == fpdp_pkg::PH_OFF) begin
                    sum_next = sum_add[24] ? 24'hFFFFFF : sum_add[23:0];
                    if (cnt_reg != 16'hFFFF) begin
                        cnt_next = cnt_reg + 16'd1;
                    end
                    if (wp_new == 12'd0) begin
                        saw_next = 1'b1;
                    end
                end
            end
            if (elapsed_reg != TMAX) begin
                elapsed_next = elapsed_reg + TW'(1);
            end
        end

        if (cmd.decide) begin
            if (prime_reg) begin
                if (phase_reg != fpdp_pkg::PH_PRIME) begin
                    phase_next   = fpdp_pkg::PH_PRIME;
                    elapsed_next = '0;
                end
            end else begin
                unique case (phase_reg)
                    fpdp_pkg::PH_PRIME: phase_next = fpdp_pkg::PH_IDLE;
                    fpdp_pkg::PH_IDLE: lock_c_next = clamp_c(24'(latest_reg));
                    fpdp_pkg::PH_ON: begin
                        if (el_ge_on) begin
                            phase_next   = fpdp_pkg::PH_OFF;
                            elapsed_next = '0;
                        end
                    end
                    fpdp_pkg::PH_OFF: begin
                        lock_c_next = clamp_c(24'(latest_reg));
                        if (el_ge_off && saw_reg) begin
                            phase_next   = fpdp_pkg::PH_COOL;
                            elapsed_next = '0;
                        end
                    end
                    fpdp_pkg::PH_COOL: begin
                        if (el_ge_cool) begin
                            phase_next = fpdp_pkg::PH_IDLE;
                            sum_next   = '0;
                            cnt_next   = '0;
                            saw_next   = 1'b0;
                        end
                    end
                    default: phase_next = fpdp_pkg::PH_IDLE;
                endcase
            end
        end

        if (cmd.cap_avg) begin
            lock_c_next = clamp_c(div_q);
        end

        if (cmd.lock_prep) begin
            n_next       = n_w[6:0];
            onb_next     = onb_w;
            full_next    = n_onb >= tot28;
            den_next     = 16'(tot28 - n_onb);
            num_off_next = 15'd28 * 15'(offb_w);
            on_raw_next  = 24'(tot_w);
            off_raw_next = '0;
        end

        if (cmd.cap_off) begin
            off_raw_next = div_q[10:0];
        end
        if (cmd.mul1) begin
            p1_next = 17'(off_raw_reg) * 17'(n_reg);
        end
        if (cmd.mul2) begin
            p2_next = 24'(p1_reg) * 24'(onb_reg);
        end
        if (cmd.cap_on) begin
            on_raw_next = div_q;
        end

        if (cmd.commit) begin
            on_time_next  = on_sat;
            off_time_next = (off_raw_reg > 11'd1000) ? 10'd1000 : off_raw_reg[9:0];
            sum_next      = '0;
            cnt_next      = '0;
            saw_next      = 1'b0;
            phase_next    = fpdp_pkg::PH_ON;
            elapsed_next  = '0;
        end

        if (cmd.finish) begin
            valve_next = fin_valve;
            blvl_next  = fin_lvl;
            bel_next   = fin_bel;
            out_next   = '0;
            out_next[0]     = phase_reg == fpdp_pkg::PH_ON || phase_reg == fpdp_pkg::PH_PRIME;
            out_next[1]     = fin_valve;
            out_next[2]     = flavor_reg;
            out_next[3]     = !flavor_reg && led_lvl;
            out_next[4]     = flavor_reg && led_lvl;
            out_next[7:5]   = phase_reg;
            out_next[31:8]  = on_ext[23:0];
            out_next[41:32] = off_time_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ratio1_reg   <= 5'd20;
            ratio2_reg   <= 5'd20;
            window_reg   <= 8'd50;
            cool_reg     <= 12'd1000;
            blink_ms_reg <= 8'd50;
            phase_reg    <= fpdp_pkg::PH_IDLE;
            elapsed_reg  <= '0;
            on_time_reg  <= '0;
            off_time_reg <= '0;
            sum_reg      <= '0;
            cnt_reg      <= '0;
            saw_reg      <= 1'b0;
            wticks_reg   <= '0;
            wpulses_reg  <= '0;
            latest_reg   <= '0;
            flowing_reg  <= 1'b0;
            valve_reg    <= 1'b0;
            blvl_reg     <= 1'b1;
            bel_reg      <= '0;
            flavor_reg   <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    fpdp_pkg::CFG_RATIO1:   ratio1_reg   <= cfg_data[4:0];
                    fpdp_pkg::CFG_RATIO2:   ratio2_reg   <= cfg_data[4:0];
                    fpdp_pkg::CFG_WINDOW:   window_reg   <= cfg_data[7:0];
                    fpdp_pkg::CFG_COOLDOWN: cool_reg     <= cfg_data;
                    fpdp_pkg::CFG_BLINK:    blink_ms_reg <= cfg_data[7:0];
                    default: ;
                endcase
            end
            phase_reg    <= phase_next;
            elapsed_reg  <= elapsed_next;
            on_time_reg  <= on_time_next;
            off_time_reg <= off_time_next;
            sum_reg      <= sum_next;
            cnt_reg      <= cnt_next;
            saw_reg      <= saw_next;
            wticks_reg   <= wticks_next;
            wpulses_reg  <= wpulses_next;
            latest_reg   <= latest_next;
            flowing_reg  <= flowing_next;
            valve_reg    <= valve_next;
            blvl_reg     <= blvl_next;
            bel_reg      <= bel_next;
            flavor_reg   <= flavor_next;
        end
        if (cmd.load) begin
            pulses_reg <= s_tdata[3:0];
            sw_reg     <= s_tdata[4];
            prime_reg  <= s_tdata[5];
        end
        lock_c_reg  <= lock_c_next;
        n_reg       <= n_next;
        onb_reg     <= onb_next;
        den_reg     <= den_next;
        num_off_reg <= num_off_next;
        full_reg    <= full_next;
        off_raw_reg <= off_raw_next;
        on_raw_reg  <= on_raw_next;
        p1_reg      <= p1_next;
        p2_reg      <= p2_next;
        out_reg     <= out_next;
    end

    assign m_tdata = out_reg;
endmodule
`default_nettype wire

FILE: design/fpdp_ctrl.sv
// controller: tick sequencing, divider steps and output handshake
`default_nettype none
`include "flow_proportional_dosing_pump_unit_assert.svh"
module fpdp_ctrl (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    input  wire fpdp_pkg::dp_status_t status,
    output fpdp_pkg::dp_cmd_t         cmd
);
    fpdp_pkg::ctrl_state_t state_reg, state_next;
    logic m_tvalid_reg, m_tvalid_next;

    assign s_tready = state_reg == fpdp_pkg::ST_IDLE && (!m_tvalid_reg || m_tready);
    assign m_tvalid = m_tvalid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= fpdp_pkg::ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg;
        cmd           = '0;
        cmd.div_sel   = fpdp_pkg::DIV_AVG;
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end
        unique case (state_reg)
            fpdp_pkg::ST_IDLE: begin
                if (s_tvalid && s_tready) begin
                    cmd.load   = 1'b1;
                    state_next = fpdp_pkg::ST_PRE;
                end
            end
            fpdp_pkg::ST_PRE: begin
                cmd.pre    = 1'b1;
                state_next = fpdp_pkg::ST_DECIDE;
            end
            fpdp_pkg::ST_DECIDE: begin
                cmd.decide = 1'b1;
                if (status.need_avg) begin
                    state_next = fpdp_pkg::ST_AVG_GO;
                end else if (status.need_lock) begin
                    state_next = fpdp_pkg::ST_PREP;
                end else begin
                    state_next = fpdp_pkg::ST_FINISH;
                end
            end
            fpdp_pkg::ST_AVG_GO: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = fpdp_pkg::DIV_AVG;
                state_next    = fpdp_pkg::ST_AVG_WAIT;
            end
            fpdp_pkg::ST_AVG_WAIT: begin
                if (status.div_done) begin
                    cmd.cap_avg = 1'b1;
                    state_next  = fpdp_pkg::ST_PREP;
                end
            end
            fpdp_pkg::ST_PREP: begin
                cmd.lock_prep = 1'b1;
                state_next    = fpdp_pkg::ST_OFF_GO;
            end
            fpdp_pkg::ST_OFF_GO: begin
                // pump runs the whole cycle when the ratio leaves no off time
                if (status.full) begin
                    state_next = fpdp_pkg::ST_COMMIT;
                end else begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = fpdp_pkg::DIV_OFF;
                    state_next    = fpdp_pkg::ST_OFF_WAIT;
                end
            end
            fpdp_pkg::ST_OFF_WAIT: begin
                if (status.div_done) begin
                    cmd.cap_off = 1'b1;
                    state_next  = fpdp_pkg::ST_MUL1;
                end
            end
            fpdp_pkg::ST_MUL1: begin
                cmd.mul1   = 1'b1;
                state_next = fpdp_pkg::ST_MUL2;
            end
            fpdp_pkg::ST_MUL2: begin
                cmd.mul2   = 1'b1;
                state_next = fpdp_pkg::ST_ON_GO;
            end
            fpdp_pkg::ST_ON_GO: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = fpdp_pkg::DIV_ON;
                state_next    = fpdp_pkg::ST_ON_WAIT;
            end
            fpdp_pkg::ST_ON_WAIT: begin
                cmd.div_sel = fpdp_pkg::DIV_ON;
                if (status.div_done) begin
                    cmd.cap_on = 1'b1;
                    state_next = fpdp_pkg::ST_COMMIT;
                end
            end
            fpdp_pkg::ST_COMMIT: begin
                cmd.commit = 1'b1;
                state_next = fpdp_pkg::ST_FINISH;
            end
            fpdp_pkg::ST_FINISH: begin
                cmd.finish    = 1'b1;
                m_tvalid_next = 1'b1;
                state_next    = fpdp_pkg::ST_IDLE;
            end
            default: state_next = fpdp_pkg::ST_IDLE;
        endcase
    end

    `FPDP_ASSERT_SAME(a_no_overrun, s_tvalid && s_tready, !m_tvalid_reg || m_tready, "input taken over pending result")
    `FPDP_ASSERT_NEXT(a_finish_valid, state_reg == fpdp_pkg::ST_FINISH, m_tvalid_reg && state_reg == fpdp_pkg::ST_IDLE, "result not presented after finish")
    `FPDP_ASSERT_SAME(a_done_waiting, status.div_done, state_reg == fpdp_pkg::ST_AVG_WAIT || state_reg == fpdp_pkg::ST_OFF_WAIT || state_reg == fpdp_pkg::ST_ON_WAIT, "divider done outside a wait state")
endmodule
`default_nettype wire
